FILE: hdl/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// Shared types, constants and the symbol table of the Morse character encoder.
// ----------------------------------------------------------------------------
package mce_pkg;

    localparam int CharW   = 8;
    localparam int TimeW   = 10;
    localparam int DivW    = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;
    localparam int LenW    = 3;
    localparam int MaxElem = 5;
    localparam int TdataW  = 32;
    localparam int NumSym  = 36;
    localparam int SymIdxW = 6;

    localparam logic [TimeW-1:0] DotTimeRst    = 10'd150;
    localparam logic [TimeW-1:0] DashTimeRst   = 10'd350;
    localparam logic [TimeW-1:0] ElemGapRst    = 10'd500;
    localparam logic [TimeW-1:0] CharGapRst    = 10'd750;
    localparam logic [DivW-1:0]  ToneDivRst    = 16'd2711;

    localparam logic [CharW-1:0] ChDigit0 = 8'h30;
    localparam logic [CharW-1:0] ChDigit9 = 8'h39;
    localparam logic [CharW-1:0] ChLowA   = 8'h61;
    localparam logic [CharW-1:0] ChLowZ   = 8'h7a;
    localparam logic [CharW-1:0] ChUpA    = 8'h41;
    localparam logic [CharW-1:0] ChUpZ    = 8'h5a;
    localparam logic [SymIdxW-1:0] DigitBase = 6'd26;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DOT_TIME  = 3'd0,
        REG_DASH_TIME = 3'd1,
        REG_ELEM_GAP  = 3'd2,
        REG_CHAR_GAP  = 3'd3,
        REG_TONE_DIV  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TONE = 2'd1,
        ST_GAP  = 2'd2,
        ST_LAST = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        SEG_TONE = 2'd0,
        SEG_GAP  = 2'd1,
        SEG_LAST = 2'd2
    } seg_kind_t;

    typedef struct packed {
        logic      load;
        logic      advance;
        seg_kind_t seg;
    } cmd_t;

    typedef struct packed {
        logic char_ok;
        logic last_elem;
    } stat_t;

    typedef struct packed {
        logic                ok;
        logic [LenW-1:0]     len;
        logic [MaxElem-1:0]  pattern;
    } sym_t;

    // entries 0..25 are letters, 26..35 digits; element i of n is bit n-1-i, 1 = dash
    localparam logic [LenW-1:0] SymLen [NumSym] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
        3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };
    localparam logic [MaxElem-1:0] SymBits [NumSym] = '{
        5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4,
        5'd3, 5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9,
        5'd11, 5'd12,
        5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
    };

    // pattern comes back left aligned so the first element sits in the top bit
    function automatic sym_t sym_lookup(input logic [CharW-1:0] ch);
        sym_t               r;
        logic [SymIdxW-1:0] idx;
        r   = '0;
        idx = '0;
        r.ok = 1'b1;
        if (ch >= ChDigit0 && ch <= ChDigit9) begin
            idx = SymIdxW'(ch - ChDigit0) + DigitBase;
        end else if (ch >= ChLowA && ch <= ChLowZ) begin
            idx = SymIdxW'(ch - ChLowA);
        end else if (ch >= ChUpA && ch <= ChUpZ) begin
            idx = SymIdxW'(ch - ChUpA);
        end else begin
            r.ok = 1'b0;
        end
        r.len     = SymLen[idx];
        r.pattern = MaxElem'(SymBits[idx] << (LenW'(MaxElem) - SymLen[idx]));
        return r;
    endfunction

endpackage

FILE: hdl/mce_dp.sv
// ----------------------------------------------------------------------------
// mce_dp
// Datapath: timing registers, symbol decode, element shifter and segment mux.
// ----------------------------------------------------------------------------
module mce_dp import mce_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]      cfg_wdata,
    input  logic [CharW-1:0]     character,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 tone_on,
    output logic [TimeW-1:0]     duration,
    output logic [DivW-1:0]      pitch_divisor,
    output logic                 last_segment
);

    logic [TimeW-1:0]   dot_time_reg;
    logic [TimeW-1:0]   dash_time_reg;
    logic [TimeW-1:0]   elem_gap_reg;
    logic [TimeW-1:0]   char_gap_reg;
    logic [DivW-1:0]    tone_div_reg;
    logic [MaxElem-1:0] pattern_reg;
    logic [MaxElem-1:0] pattern_next;
    logic [LenW-1:0]    count_reg;
    logic [LenW-1:0]    count_next;
    sym_t               sym;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_time_reg  <= DotTimeRst;
            dash_time_reg <= DashTimeRst;
            elem_gap_reg  <= ElemGapRst;
            char_gap_reg  <= CharGapRst;
            tone_div_reg  <= ToneDivRst;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DOT_TIME:  dot_time_reg  <= cfg_wdata[TimeW-1:0];
                REG_DASH_TIME: dash_time_reg <= cfg_wdata[TimeW-1:0];
                REG_ELEM_GAP:  elem_gap_reg  <= cfg_wdata[TimeW-1:0];
                REG_CHAR_GAP:  char_gap_reg  <= cfg_wdata[TimeW-1:0];
                REG_TONE_DIV:  tone_div_reg  <= cfg_wdata[DivW-1:0];
                default: ;
            endcase
        end
    end

    assign sym = sym_lookup(character);

    always_comb begin
        pattern_next = pattern_reg;
        count_next   = count_reg;
        if (cmd.load) begin
            pattern_next = sym.pattern;
            count_next   = sym.len;
        end else if (cmd.advance) begin
            pattern_next = {pattern_reg[MaxElem-2:0], 1'b0};
            count_next   = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        pattern_reg <= pattern_next;
        count_reg   <= count_next;
    end

    assign stat.char_ok   = sym.ok;
    assign stat.last_elem = (count_reg == LenW'(1));

    always_comb begin
        tone_on       = 1'b0;
        duration      = elem_gap_reg;
        pitch_divisor = '0;
        last_segment  = 1'b0;
        unique case (cmd.seg)
            SEG_TONE: begin
                tone_on       = 1'b1;
                duration      = pattern_reg[MaxElem-1] ? dash_time_reg : dot_time_reg;
                pitch_divisor = tone_div_reg;
            end
            SEG_GAP: begin
                duration = elem_gap_reg;
            end
            SEG_LAST: begin
                duration     = char_gap_reg;
                last_segment = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/mce_ctrl.sv
// ----------------------------------------------------------------------------
// mce_ctrl
// Controller: walks tone and gap segments of one character, then the char gap.
// ----------------------------------------------------------------------------
module mce_ctrl import mce_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // unsupported characters are taken and dropped
                if (s_tvalid && stat.char_ok) begin
                    state_next = ST_TONE;
                end
            end
            ST_TONE: begin
                if (m_tready) begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP: begin
                if (m_tready) begin
                    state_next = stat.last_elem ? ST_LAST : ST_TONE;
                end
            end
            ST_LAST: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.seg     = SEG_GAP;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_TONE: begin
                m_tvalid = 1'b1;
                cmd.seg  = SEG_TONE;
            end
            ST_GAP: begin
                m_tvalid    = 1'b1;
                cmd.seg     = SEG_GAP;
                cmd.advance = m_tready;
            end
            ST_LAST: begin
                m_tvalid = 1'b1;
                cmd.seg  = SEG_LAST;
            end
            default: ;
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a segment is pending");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && state_reg == ST_LAST) |=> s_tready)
        else $error("controller did not return to idle after char gap");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(state_reg))
        else $error("segment changed while stalled");

    a_gap_follows_tone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TONE && m_tready) |=> (state_reg == ST_GAP))
        else $error("tone segment not followed by element gap");

endmodule

FILE: hdl/morse_character_encoder_core.sv
// ----------------------------------------------------------------------------
// morse_character_encoder_core
// ASCII character in, Morse tone and silence segments out.
// ----------------------------------------------------------------------------
// latency: first segment is presented the cycle after the character is taken
// the controller walks a tone and a gap per element of the character, then the char gap,
// and takes no new character until the char gap is accepted; m_tready low holds a segment
// unsupported characters are taken and give no segments
// reset (aresetn low, synchronous) returns to idle and reloads default timings
module morse_character_encoder_core import mce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CharW-1:0]    s_tdata,   // [7:0] character
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TdataW-1:0]   m_tdata,   // [9:0] duration, [25:10] pitch_divisor
    output logic                m_tuser,   // [0] tone_on
    output logic                m_tlast    // last_segment
);

    cmd_t             cmd;
    stat_t            stat;
    logic [TimeW-1:0] duration;
    logic [DivW-1:0]  pitch_divisor;

    mce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mce_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .character     (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .tone_on       (m_tuser),
        .duration      (duration),
        .pitch_divisor (pitch_divisor),
        .last_segment  (m_tlast)
    );

    assign m_tdata = {(TdataW - TimeW - DivW)'(0), pitch_divisor, duration};

endmodule
